[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the line rasteriser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/blr_pkg.sv]
// Types and constants shared by the Bresenham line rasteriser modules.
package blr_pkg;

   localparam int COORD_W              = 6;
   localparam int ERR_W                = 8;
   localparam int QUEUE_DEPTH          = 2;
   localparam int DEFAULT_SCREEN_WIDTH  = 64;
   localparam int DEFAULT_SCREEN_HEIGHT = 64;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic signed [7:0] start_x;
      logic signed [7:0] start_y;
      logic signed [7:0] end_x;
      logic signed [7:0] end_y;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
   } req_type;

   typedef struct packed {
      logic [5:0]  pixel_x;
      logic [5:0]  pixel_y;
      logic [31:0] pixel_value;
      logic        last_pixel;
      logic        offscreen_error;
   } rsp_type;

   // A classified line command, ready for the stepping engine.
   typedef struct packed {
      logic               offscreen;
      logic               steep;
      logic [COORD_W-1:0] major_start;
      logic [COORD_W-1:0] major_end;
      logic [COORD_W-1:0] minor_start;
      logic [COORD_W-1:0] delta_major;
      logic [COORD_W-1:0] delta_minor;
      logic               minor_down;
      logic [23:0]        colour;
   } cmd_type;

endpackage

[hdl/blr_front.sv]
// Front end: accepts line commands, checks the endpoints and orders the axes.
module blr_front #(
   parameter int SCREEN_WIDTH  = blr_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = blr_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  blr_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output blr_pkg::cmd_type cmd_data
);

   localparam int CW = blr_pkg::COORD_W;

   logic             valid_ff, valid_in;
   blr_pkg::cmd_type cmd_ff, cmd_in;

   logic              on_a, on_b, steep, swap;
   logic [CW-1:0]     ax, ay, bx, by;
   logic signed [CW:0] dxs, dys;
   logic [CW:0]       adx, ady;
   logic [CW-1:0]     maj_a, maj_b, min_a, min_b;
   logic [CW-1:0]     min_s, min_e;

   assign req_ready = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      on_a = !req_data.start_x[7] && (req_data.start_x[6:0] < 7'(SCREEN_WIDTH)) &&
             !req_data.start_y[7] && (req_data.start_y[6:0] < 7'(SCREEN_HEIGHT));
      on_b = !req_data.end_x[7] && (req_data.end_x[6:0] < 7'(SCREEN_WIDTH)) &&
             !req_data.end_y[7] && (req_data.end_y[6:0] < 7'(SCREEN_HEIGHT));
      ax = req_data.start_x[CW-1:0];
      ay = req_data.start_y[CW-1:0];
      bx = req_data.end_x[CW-1:0];
      by = req_data.end_y[CW-1:0];
      dxs = $signed({1'b0, bx}) - $signed({1'b0, ax});
      dys = $signed({1'b0, by}) - $signed({1'b0, ay});
      adx = dxs[CW] ? (CW+1)'(-dxs) : dxs;
      ady = dys[CW] ? (CW+1)'(-dys) : dys;
      steep = ady > adx;
      maj_a = steep ? ay : ax;
      maj_b = steep ? by : bx;
      min_a = steep ? ax : ay;
      min_b = steep ? bx : by;
      swap  = maj_a > maj_b;
      min_s = swap ? min_b : min_a;
      min_e = swap ? min_a : min_b;

      cmd_in.offscreen   = !(on_a && on_b);
      cmd_in.steep       = steep;
      cmd_in.major_start = swap ? maj_b : maj_a;
      cmd_in.major_end   = swap ? maj_a : maj_b;
      cmd_in.minor_start = min_s;
      cmd_in.delta_major = swap ? (maj_a - maj_b) : (maj_b - maj_a);
      cmd_in.minor_down  = min_s > min_e;
      cmd_in.delta_minor = (min_s > min_e) ? (min_s - min_e) : (min_e - min_s);
      cmd_in.colour      = {req_data.red, req_data.green, req_data.blue};

      valid_in = (valid_ff && !cmd_ready) || req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

[hdl/blr_queue.sv]
// Short command queue between the front end and the stepping engine.
module blr_queue #(
   parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  blr_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output blr_pkg::cmd_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   blr_pkg::cmd_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/blr_back.sv]
// Stepping engine: walks each queued line and drives the pixel result register.
module blr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  blr_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output blr_pkg::rsp_type rsp_data
);

   localparam int CW = blr_pkg::COORD_W;
   localparam int EW = blr_pkg::ERR_W;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   blr_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              steep_ff, steep_in;
   logic              down_ff, down_in;
   logic [CW-1:0]     major_ff, major_in;
   logic [CW-1:0]     major_end_ff, major_end_in;
   logic [CW-1:0]     minor_ff, minor_in;
   logic [CW-1:0]     dmaj_ff, dmaj_in;
   logic [CW-1:0]     dmin_ff, dmin_in;
   logic signed [EW-1:0] err_ff, err_in, err_sub;
   logic [23:0]       colour_ff, colour_in;
   logic              slot_free, at_end;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign at_end    = major_ff == major_end_ff;
   assign err_sub   = err_ff - $signed({{(EW-CW){1'b0}}, dmin_ff});

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      steep_in     = steep_ff;
      down_in      = down_ff;
      major_in     = major_ff;
      major_end_in = major_end_ff;
      minor_in     = minor_ff;
      dmaj_in      = dmaj_ff;
      dmin_in      = dmin_ff;
      err_in       = err_ff;
      colour_in    = colour_ff;
      cmd_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd_data.offscreen) begin
                  if (slot_free) begin
                     cmd_ready    = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_data_in.last_pixel      = 1'b1;
                     rsp_data_in.offscreen_error = 1'b1;
                  end
               end else begin
                  cmd_ready    = 1'b1;
                  steep_in     = cmd_data.steep;
                  down_in      = cmd_data.minor_down;
                  major_in     = cmd_data.major_start;
                  major_end_in = cmd_data.major_end;
                  minor_in     = cmd_data.minor_start;
                  dmaj_in      = cmd_data.delta_major;
                  dmin_in      = cmd_data.delta_minor;
                  err_in       = {{(EW-CW+1){1'b0}}, cmd_data.delta_major[CW-1:1]};
                  colour_in    = cmd_data.colour;
                  state_in     = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.pixel_x         = steep_ff ? minor_ff : major_ff;
               rsp_data_in.pixel_y         = steep_ff ? major_ff : minor_ff;
               rsp_data_in.pixel_value     = {blr_pkg::ALPHA_OPAQUE, colour_ff};
               rsp_data_in.last_pixel      = at_end;
               rsp_data_in.offscreen_error = 1'b0;
               major_in = major_ff + 1'b1;
               if (err_sub < 0) begin
                  minor_in = down_ff ? minor_ff - 1'b1 : minor_ff + 1'b1;
                  err_in   = err_sub + $signed({{(EW-CW){1'b0}}, dmaj_ff});
               end else begin
                  err_in = err_sub;
               end
               if (at_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      steep_ff     <= steep_in;
      down_ff      <= down_in;
      major_ff     <= major_in;
      major_end_ff <= major_end_in;
      minor_ff     <= minor_in;
      dmaj_ff      <= dmaj_in;
      dmin_ff      <= dmin_in;
      err_ff       <= err_in;
      colour_ff    <= colour_in;
   end

endmodule

[hdl/bresenham_line_rasterizer_top.sv]
// A line's first pixel passes the front-end command register, a queue entry, the
// stepping engine's command registers and its pixel result register before it is offered.
// The stepping engine loads a command only in its idle state, then issues one pixel per
// cycle while the result side does not stall; an off-screen command gives one error result.
// Reset is synchronous and active high; it empties the queue and all valid flags at once,
// and no clearing pass follows.
module bresenham_line_rasterizer_top #(
   parameter int SCREEN_WIDTH  = blr_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = blr_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  blr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output blr_pkg::rsp_type rsp_data
);

   // The front end registers one classified command. The check for off-screen endpoints,
   // the choice of the driving axis and the ordering of the endpoints all happen there,
   // so the stepping engine only has to count along the driving axis.
   logic             front_valid, front_ready;
   blr_pkg::cmd_type front_cmd;

   // The queue lets the front end take the next command while a long line is still
   // being drawn, and lets the stepping engine stall on the result side on its own.
   logic             queue_valid, queue_ready;
   blr_pkg::cmd_type queue_cmd;

   blr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) front_inst (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd_data  (front_cmd)
   );

   blr_queue #(
      .DEPTH (blr_pkg::QUEUE_DEPTH)
   ) queue_inst (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   // The stepping engine holds each pixel in its result register until the transfer
   // completes, and only then advances the error term and the coordinates.
   blr_back back_inst (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd_data  (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/blr_checker.sv]
// Port-level checker for the line rasteriser, bound to the top level.
`include "assert_macros.svh"

module blr_checker #(
   parameter int SCREEN_WIDTH  = blr_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = blr_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input blr_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input blr_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(rsp_holds_while_stalled, clock, reset,
                rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_data))

   `ASSERT_IMPLIES(error_result_is_clean, clock, reset,
                   rsp_valid && rsp_data.offscreen_error,
                   rsp_data.last_pixel && (rsp_data.pixel_x == 6'd0) &&
                   (rsp_data.pixel_y == 6'd0) && (rsp_data.pixel_value == 32'd0))

   `ASSERT_IMPLIES(pixel_is_opaque, clock, reset,
                   rsp_valid && !rsp_data.offscreen_error,
                   rsp_data.pixel_value[31:24] == blr_pkg::ALPHA_OPAQUE)

   `ASSERT_IMPLIES(pixel_on_screen, clock, reset,
                   rsp_valid && !rsp_data.offscreen_error,
                   ({1'b0, rsp_data.pixel_x} < 7'(SCREEN_WIDTH)) &&
                   ({1'b0, rsp_data.pixel_y} < 7'(SCREEN_HEIGHT)))

endmodule

bind bresenham_line_rasterizer_top blr_checker #(
   .SCREEN_WIDTH  (SCREEN_WIDTH),
   .SCREEN_HEIGHT (SCREEN_HEIGHT)
) checker_inst (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
